// ----- hw/rtl/obns_pkg.sv -----
// Shared types and constants for the octave bilinear noise sampler.
package obns_pkg;

    localparam int NP_SIZE_DEF    = 128;
    localparam int DEC_BITS_DEF   = 12;
    localparam int PACK_SHIFT_DEF = 4;
    localparam int MAX_PACKS_DEF  = 4;

    localparam int TABLE_DEPTH = 65536;
    localparam int TABLE_AW    = 16;
    localparam int TEXEL_W     = 16;
    localparam int COORD_W     = 32;
    localparam int HEIGHT_W    = 18;
    localparam int ACC_W       = 20;
    localparam int CFG_W       = 3;

    localparam logic signed [ACC_W-1:0] HS_MAX = ACC_W'(131071);
    localparam logic signed [ACC_W-1:0] HS_MIN = -ACC_W'(131072);

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_MUL_ROW,
        ST_ADD_ROW,
        ST_MUL_COL,
        ST_ACC,
        ST_DONE
    } obns_state_t;

    typedef struct packed {
        logic       wr_en;
        logic       load;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       mul_row;
        logic       add_row;
        logic       mul_col;
        logic       acc;
        logic       out_load;
    } obns_cmd_t;

    typedef struct packed {
        logic packs_zero;
        logic pack_last;
        logic out_busy;
    } obns_status_t;

endpackage

// ----- hw/rtl/obns_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module obns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- hw/rtl/obns_ctrl.sv -----
// Sequencer for texel fetch, interpolation steps and result hand-off.
module obns_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_operation,
    output logic                  s_ready,
    input  obns_pkg::obns_status_t status,
    output obns_pkg::obns_cmd_t   cmd
);
    import obns_pkg::*;

    obns_state_t state_reg, state_next;
    logic [1:0]  cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cnt_next = '0;
                if (s_valid) begin
                    if (s_operation == OP_WRITE) begin
                        cmd.wr_en = 1'b1;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = status.packs_zero ? ST_DONE : ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = cnt_reg;
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:    state_next = ST_MUL_ROW;
            ST_MUL_ROW: begin
                cmd.mul_row = 1'b1;
                state_next  = ST_ADD_ROW;
            end
            ST_ADD_ROW: begin
                cmd.add_row = 1'b1;
                state_next  = ST_MUL_COL;
            end
            ST_MUL_COL: begin
                cmd.mul_col = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = status.pack_last ? ST_DONE : ST_READ;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ----- hw/rtl/obns_dpath.sv -----
// Datapath: texel table, address generation, interpolation and accumulation.
module obns_dpath #(
    parameter int NP_SIZE    = obns_pkg::NP_SIZE_DEF,
    parameter int DEC_BITS   = obns_pkg::DEC_BITS_DEF,
    parameter int PACK_SHIFT = obns_pkg::PACK_SHIFT_DEF,
    parameter int MAX_PACKS  = obns_pkg::MAX_PACKS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [obns_pkg::CFG_W-1:0]             cfg_wr_data,
    input  logic [obns_pkg::TABLE_AW-1:0]          s_table_address,
    input  logic signed [obns_pkg::TEXEL_W-1:0]    s_texel_value,
    input  logic signed [obns_pkg::COORD_W-1:0]    s_u_coord,
    input  logic signed [obns_pkg::COORD_W-1:0]    s_v_coord,
    input  logic                                   m_ready,
    output logic                                   m_valid,
    output logic signed [obns_pkg::HEIGHT_W-1:0]   m_height_sum,
    input  obns_pkg::obns_cmd_t                    cmd,
    output obns_pkg::obns_status_t                 status
);
    import obns_pkg::*;

    localparam int NB  = $clog2(NP_SIZE);
    localparam int PW  = $clog2(MAX_PACKS + 1);
    localparam int FW  = DEC_BITS + 1;
    localparam int MW  = FW + 1 + TEXEL_W;

    logic [CFG_W-1:0]               active_packs_reg;
    logic [PW-1:0]                  packs_reg, pack_reg;
    logic [COORD_W-1:0]             u_reg, v_reg;
    logic signed [TEXEL_W-1:0]      tex_reg [4];
    logic                           rd_en_d_reg;
    logic [1:0]                     rd_sel_d_reg;
    logic signed [MW-1:0]           p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [TEXEL_W-1:0]      top_reg, bot_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic                           m_valid_reg;
    logic signed [HEIGHT_W-1:0]     height_reg;
    logic [TEXEL_W-1:0]             rd_data;

    logic [DEC_BITS-1:0]            fu, fv;
    logic signed [FW:0]             wu_s, fu_s, wv_s, fv_s;
    logic [NB-1:0]                  col0, col1, row0, row1, col_sel, row_sel;
    logic [TABLE_AW-1:0]            rd_addr;
    logic signed [MW:0]             sum_top, sum_bot, sum_col;
    logic signed [TEXEL_W-1:0]      pack_val;
    logic [3:0]                     packs_sat;

    // Fraction weights.
    assign fu   = u_reg[DEC_BITS-1:0];
    assign fv   = v_reg[DEC_BITS-1:0];
    assign fu_s = signed'({2'b00, fu});
    assign fv_s = signed'({2'b00, fv});
    assign wu_s = signed'((FW + 1)'(1 << DEC_BITS)) - fu_s;
    assign wv_s = signed'((FW + 1)'(1 << DEC_BITS)) - fv_s;

    // Wrapped texel coordinates.
    assign col0    = u_reg[DEC_BITS +: NB];
    assign col1    = col0 + NB'(1);
    assign row0    = v_reg[DEC_BITS +: NB];
    assign row1    = row0 + NB'(1);
    assign col_sel = cmd.rd_sel[0] ? col1 : col0;
    assign row_sel = cmd.rd_sel[1] ? row1 : row0;
    assign rd_addr = TABLE_AW'((32'(pack_reg) << (2 * NB)) + (32'(row_sel) << NB)
                     + 32'(col_sel));

    assign sum_top  = (MW + 1)'(p0_reg) + (MW + 1)'(p1_reg);
    assign sum_bot  = (MW + 1)'(p2_reg) + (MW + 1)'(p3_reg);
    assign sum_col  = (MW + 1)'(p0_reg) + (MW + 1)'(p1_reg);
    assign pack_val = TEXEL_W'(sum_col >>> DEC_BITS);

    assign packs_sat = ({1'b0, active_packs_reg} > 4'(MAX_PACKS)) ? 4'(MAX_PACKS)
                       : {1'b0, active_packs_reg};

    assign status.packs_zero = (active_packs_reg == '0);
    assign status.pack_last  = ((pack_reg + PW'(1)) == packs_reg);
    assign status.out_busy   = m_valid_reg && !m_ready;

    obns_ram #(
        .WIDTH(TEXEL_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (cmd.wr_en),
        .wr_addr(s_table_address),
        .wr_data(s_texel_value),
        .rd_en  (cmd.rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_packs_reg <= '0;
            rd_en_d_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                active_packs_reg <= cfg_wr_data;
            end
            rd_en_d_reg <= cmd.rd_en;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_sel_d_reg <= cmd.rd_sel;
        if (rd_en_d_reg) begin
            tex_reg[rd_sel_d_reg] <= signed'(rd_data);
        end
        if (cmd.load) begin
            u_reg     <= COORD_W'(s_u_coord);
            v_reg     <= COORD_W'(s_v_coord);
            pack_reg  <= '0;
            packs_reg <= PW'(packs_sat);
            acc_reg   <= '0;
        end
        if (cmd.mul_row) begin
            p0_reg <= MW'(wu_s) * MW'(tex_reg[0]);
            p1_reg <= MW'(fu_s) * MW'(tex_reg[1]);
            p2_reg <= MW'(wu_s) * MW'(tex_reg[2]);
            p3_reg <= MW'(fu_s) * MW'(tex_reg[3]);
        end
        if (cmd.add_row) begin
            top_reg <= TEXEL_W'(sum_top >>> DEC_BITS);
            bot_reg <= TEXEL_W'(sum_bot >>> DEC_BITS);
        end
        if (cmd.mul_col) begin
            p0_reg <= MW'(wv_s) * MW'(top_reg);
            p1_reg <= MW'(fv_s) * MW'(bot_reg);
        end
        if (cmd.acc) begin
            acc_reg  <= acc_reg + ACC_W'(pack_val);
            u_reg    <= u_reg << PACK_SHIFT;
            v_reg    <= v_reg << PACK_SHIFT;
            pack_reg <= pack_reg + PW'(1);
        end
        if (cmd.out_load) begin
            priority if (acc_reg > HS_MAX) begin
                height_reg <= HEIGHT_W'(HS_MAX);
            end else if (acc_reg < HS_MIN) begin
                height_reg <= HEIGHT_W'(HS_MIN);
            end else begin
                height_reg <= HEIGHT_W'(acc_reg);
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_height_sum = height_reg;
endmodule

// ----- hw/rtl/octave_bilinear_noise_sampler.sv -----
// Write transfer: stored in the texel table, no result.
// Sample transfer: per pack 4 table reads, a read-latency wait, row multiply, row add,
// column multiply and accumulate; then the saturated sum is loaded into the result register.
// Only one transfer is processed at a time; a held result stalls the input.
// Synchronous active-low reset clears control, the result valid and
// active_packs; the texel table is not cleared and holds garbage until written.
module octave_bilinear_noise_sampler #(
    parameter int NP_SIZE    = obns_pkg::NP_SIZE_DEF,
    parameter int DEC_BITS   = obns_pkg::DEC_BITS_DEF,
    parameter int PACK_SHIFT = obns_pkg::PACK_SHIFT_DEF,
    parameter int MAX_PACKS  = obns_pkg::MAX_PACKS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [obns_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_operation,
    input  logic [obns_pkg::TABLE_AW-1:0]        s_table_address,
    input  logic signed [obns_pkg::TEXEL_W-1:0]  s_texel_value,
    input  logic signed [obns_pkg::COORD_W-1:0]  s_u_coord,
    input  logic signed [obns_pkg::COORD_W-1:0]  s_v_coord,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [obns_pkg::HEIGHT_W-1:0] m_height_sum
);
    import obns_pkg::*;

    obns_cmd_t    cmd;
    obns_status_t status;

    // Sequencer: decodes the transfer, steps the fetch and math phases per pack.
    obns_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_operation(s_operation),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: table, addressing, multipliers, accumulator and result register.
    obns_dpath #(
        .NP_SIZE   (NP_SIZE),
        .DEC_BITS  (DEC_BITS),
        .PACK_SHIFT(PACK_SHIFT),
        .MAX_PACKS (MAX_PACKS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_table_address(s_table_address),
        .s_texel_value  (s_texel_value),
        .s_u_coord      (s_u_coord),
        .s_v_coord      (s_v_coord),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_height_sum   (m_height_sum),
        .cmd            (cmd),
        .status         (status)
    );
endmodule

// ----- test/octave_bilinear_noise_sampler_tb.sv -----
// Self-checking testbench for the octave bilinear noise sampler.
module octave_bilinear_noise_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import obns_pkg::*;

    localparam int NP       = 128;
    localparam int FRAC     = 12;
    localparam int SHIFT    = 4;
    localparam int PACK_CAP = 4;
    localparam int DRAIN    = 2 + 8 * PACK_CAP + 16;
    localparam longint CYCLE_LIMIT = 2000000;

    // Predicts height sums from the texel table and pack count it mirrors.
    class height_scoreboard;
        logic signed [TEXEL_W-1:0] texels [TABLE_DEPTH];
        bit                        written [TABLE_DEPTH];
        int                        packs;
        logic signed [HEIGHT_W-1:0] expected_heights [$];
        int                        errors;

        function new();
            packs  = 0;
            errors = 0;
        endfunction

        function void set_packs(logic [CFG_W-1:0] value);
            packs = (value > PACK_CAP) ? PACK_CAP : int'(value);
        endfunction

        function logic [TABLE_AW-1:0] texel_index(bit [31:0] u, bit [31:0] v, int p,
                                                  bit dc, bit dr);
            bit [31:0] col;
            bit [31:0] row;
            col = ((u >> FRAC) + dc) & (NP - 1);
            row = ((v >> FRAC) + dr) & (NP - 1);
            return TABLE_AW'(p * NP * NP + row * NP + col);
        endfunction

        // Collect the table entries that a sample at (u, v) would read but are unwritten.
        function void unwritten_taps(bit [31:0] u, bit [31:0] v,
                                     ref logic [TABLE_AW-1:0] missing [$]);
            logic [TABLE_AW-1:0] idx;
            for (int p = 0; p < packs; p++) begin
                for (int k = 0; k < 4; k++) begin
                    idx = texel_index(u, v, p, k[0], k[1]);
                    if (!written[idx]) missing.push_back(idx);
                end
                u = u << SHIFT;
                v = v << SHIFT;
            end
        endfunction

        function longint pack_height(bit [31:0] u, bit [31:0] v, int p);
            longint fu, fv, t00, t01, t10, t11, top, bot;
            fu  = longint'(u & ((1 << FRAC) - 1));
            fv  = longint'(v & ((1 << FRAC) - 1));
            t00 = texels[texel_index(u, v, p, 0, 0)];
            t01 = texels[texel_index(u, v, p, 1, 0)];
            t10 = texels[texel_index(u, v, p, 0, 1)];
            t11 = texels[texel_index(u, v, p, 1, 1)];
            top = (((longint'(1) << FRAC) - fu) * t00 + fu * t01) >>> FRAC;
            bot = (((longint'(1) << FRAC) - fu) * t10 + fu * t11) >>> FRAC;
            return (((longint'(1) << FRAC) - fv) * top + fv * bot) >>> FRAC;
        endfunction

        function void note_input(logic op, logic [TABLE_AW-1:0] addr,
                                 logic signed [TEXEL_W-1:0] texel,
                                 bit [31:0] u, bit [31:0] v);
            longint sum;
            if (op == OP_WRITE) begin
                texels[addr]  = texel;
                written[addr] = 1'b1;
                return;
            end
            sum = 0;
            for (int p = 0; p < packs; p++) begin
                sum += pack_height(u, v, p);
                u = u << SHIFT;
                v = v << SHIFT;
            end
            if (sum > 131071) sum = 131071;
            if (sum < -131072) sum = -131072;
            expected_heights.push_back(HEIGHT_W'(sum));
        endfunction

        function void check(logic signed [HEIGHT_W-1:0] actual);
            logic signed [HEIGHT_W-1:0] want;
            if (expected_heights.size() == 0) begin
                $error("height_sum: unexpected result %0d", actual);
                errors++;
                return;
            end
            want = expected_heights.pop_front();
            if (actual !== want) begin
                $error("height_sum: expected %0d, actual %0d", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [CFG_W-1:0]            cfg_wr_data;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_operation;
    logic [TABLE_AW-1:0]         s_table_address;
    logic signed [TEXEL_W-1:0]   s_texel_value;
    logic signed [COORD_W-1:0]   s_u_coord;
    logic signed [COORD_W-1:0]   s_v_coord;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [HEIGHT_W-1:0]  m_height_sum;

    height_scoreboard sb;
    longint           cycle;

    octave_bilinear_noise_sampler dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_table_address (s_table_address),
        .s_texel_value   (s_texel_value),
        .s_u_coord       (s_u_coord),
        .s_v_coord       (s_v_coord),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_height_sum    (m_height_sum)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Quiet window: neither side idles while the cycle count is in this range.
    function automatic bit quiet_window();
        return cycle >= 3000 && cycle < 5000;
    endfunction

    // Count cycles, check every result transfer, and stop on a runaway run.
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (aresetn && m_valid && m_ready) sb.check(m_height_sum);
        if (cycle > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up
    // and stalls its input while the sender keeps offering items.
    initial begin
        int holdoff;
        holdoff = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (cycle == 1500) holdoff = 600;
            if (holdoff > 0) begin
                holdoff--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet_window() || ($urandom_range(0, 99) >= 13);
            end
        end
    end

    // Offer one item; called and returning at a falling edge.
    task automatic send_item(logic op, logic [TABLE_AW-1:0] addr,
                             logic signed [TEXEL_W-1:0] texel,
                             logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        while (!quiet_window() && $urandom_range(0, 99) < 13) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_table_address <= addr;
        s_texel_value   <= texel;
        s_u_coord       <= u;
        s_v_coord       <= v;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(op, addr, texel, u, v);
        @(negedge aclk);
    endtask

    task automatic write_texel(logic [TABLE_AW-1:0] addr, logic signed [TEXEL_W-1:0] texel);
        send_item(OP_WRITE, addr, texel, $urandom(), $urandom());
    endtask

    // Fill any unwritten taps first so no sample ever reads an unwritten entry.
    task automatic sample_height(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        logic [TABLE_AW-1:0] missing [$];
        sb.unwritten_taps(u, v, missing);
        foreach (missing[i]) write_texel(missing[i], TEXEL_W'($urandom()));
        send_item(OP_SAMPLE, TABLE_AW'($urandom()), TEXEL_W'($urandom()), u, v);
    endtask

    // Drain all results, let the sequencer settle, then write the pack count.
    task automatic set_pack_count(logic [CFG_W-1:0] value);
        s_valid <= 1'b0;
        while (sb.expected_heights.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_packs(value);
    endtask

    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return {20'($urandom_range(0, 3)), 12'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [CFG_W-1:0] settings [8];
        settings        = '{3'd4, 3'd0, 3'd7, 3'd1, 3'd2, 3'd5, 3'd3, 3'd6};
        sb              = new();
        cycle           = 0;
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        s_valid         = 1'b0;
        s_operation     = OP_WRITE;
        s_table_address = '0;
        s_texel_value   = '0;
        s_u_coord       = '0;
        s_v_coord       = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Zero packs straight after reset: result is zero.
        sample_height(32'h1234_5678, 32'h8765_4321);

        // Directed: address and texel extremes, coordinate extremes and wrap.
        set_pack_count(3'd4);
        write_texel(16'h0000, 16'sh7FFF);
        write_texel(16'hFFFF, -16'sh8000);
        sample_height(32'h0000_0000, 32'h0000_0000);
        sample_height(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        sample_height(32'h7FFF_FFFF, 32'h8000_0000);
        sample_height(32'h8000_0000, 32'h7FFF_FFFF);
        sample_height(32'h0007_F800, 32'h0007_FFFF);
        sample_height(32'h0000_0FFF, 32'h0000_1000);

        // Random phases across pack counts, saturated counts among them.
        // Each sample also writes its unwritten taps, so keep the phases short.
        for (int ph = 0; ph < 12; ph++) begin
            set_pack_count(ph < 8 ? settings[ph] : CFG_W'($urandom()));
            for (int n = 0; n < 24; n++) begin
                if ($urandom_range(0, 99) < 25)
                    write_texel(TABLE_AW'($urandom()), TEXEL_W'($urandom()));
                else
                    sample_height(random_coord(), random_coord());
            end
        end

        s_valid <= 1'b0;
        while (sb.expected_heights.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_heights.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/obns_pkg.sv
hw/rtl/obns_ram.sv
hw/rtl/obns_ctrl.sv
hw/rtl/obns_dpath.sv
hw/rtl/octave_bilinear_noise_sampler.sv
test/octave_bilinear_noise_sampler_tb.sv
